@@ hw/rtl/tfe_pkg.sv @@
// tfe_pkg: shared constants for the timestamp field extractor
// holds the key bytes, phase codes and character codes; no dependencies
`timescale 1ns / 1ps

package tfe_pkg;

    // key "timestamp": is twelve bytes long
    localparam int unsigned KEY_LEN = 12;
    localparam int unsigned KEY_W   = 4;

    typedef logic [7:0]       t_byte;
    typedef logic [63:0]      t_stamp;
    typedef logic [KEY_W-1:0] t_key_cnt;
    typedef logic [2:0]       t_phase;

    // phase codes
    localparam t_phase PH_SEARCH   = 3'd0;
    localparam t_phase PH_SKIP     = 3'd1;
    localparam t_phase PH_DIGITS   = 3'd2;
    localparam t_phase PH_FOUND    = 3'd3;
    localparam t_phase PH_NOTFOUND = 3'd4;

    // character codes
    localparam t_byte CH_NUL   = 8'h00;
    localparam t_byte CH_TAB   = 8'h09;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_QUOTE = 8'h22;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_NINE  = 8'h39;
    localparam t_byte CH_T     = 8'h74;

    // key position of the byte after the opening quote
    localparam t_key_cnt KEY_AFTER_QUOTE = t_key_cnt'(1);
    // key position after the closing quote restarts a match and takes 't'
    localparam t_key_cnt KEY_LAST_IDX    = t_key_cnt'(KEY_LEN - 1);

    // byte of the key at a given position
    function automatic t_byte key_byte(input t_key_cnt idx);
        t_byte b;
        unique case (idx)
            4'd0:    b = CH_QUOTE;
            4'd1:    b = 8'h74; // t
            4'd2:    b = 8'h69; // i
            4'd3:    b = 8'h6d; // m
            4'd4:    b = 8'h65; // e
            4'd5:    b = 8'h73; // s
            4'd6:    b = 8'h74; // t
            4'd7:    b = 8'h61; // a
            4'd8:    b = 8'h6d; // m
            4'd9:    b = 8'h70; // p
            4'd10:   b = CH_QUOTE;
            4'd11:   b = 8'h3a; // :
            default: b = CH_NUL;
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/timestamp_field_extractor.sv @@
// timestamp_field_extractor: top level, scans one text line for "timestamp": and a number
// depends on tfe_pkg
`timescale 1ns / 1ps

// The block takes one byte of a text line per cycle and returns one transaction
// per line, on the byte flagged i_line_end: o_found and the decimal value that
// follows the first "timestamp": key (after spaces and tabs), modulo 2^64, or
// zero when that key has no number or no key was seen. A zero byte ends the line early.
// Throughput is one byte per cycle when the input does not stall. Each byte is
// scanned in the cycle after it is accepted into the input register; the result
// of a line is written to the result register as its last byte leaves the input
// register (one input register, one result register). The input stalls only
// when a last byte sits in the input register while a previous result in the result register is held by i_out_stall.
module timestamp_field_extractor
    import tfe_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic [7:0]   i_text_byte,
    input  logic         i_line_end,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic         o_found,
    output logic [63:0]  o_stamp_value
);

    // input register
    logic     r_in_valid;
    t_byte    r_in_byte;
    logic     r_in_last;

    // line scanning state
    t_phase   r_phase,   n_phase;
    t_key_cnt r_key,     n_key;
    t_stamp   r_acc,     n_acc;

    // result register
    logic     r_out_valid;
    logic     r_found;
    t_stamp   r_value;

    logic     out_free;
    logic     advance;
    logic     take_in;
    logic     is_digit;
    logic     is_blank;
    logic     ok;
    t_key_cnt key_cur;
    t_stamp   digit_val;
    t_stamp   acc_times10;

    // handshake between the two stages
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign take_in    = i_in_valid && !o_in_stall;

    // byte classification
    assign is_digit    = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);
    assign is_blank    = (r_in_byte == CH_SPACE) || (r_in_byte == CH_TAB);
    assign digit_val   = t_stamp'(r_in_byte[3:0]);
    assign acc_times10 = (r_acc << 3) + (r_acc << 1);
    assign key_cur     = (r_key >= t_key_cnt'(KEY_LEN)) ? '0 : r_key;

    // next scanning state for the byte in the input register
    always_comb begin
        n_phase = r_phase;
        n_key   = r_key;
        n_acc   = r_acc;
        unique case (r_phase)
            PH_SEARCH: begin
                if (r_in_byte == CH_NUL) begin
                    n_phase = PH_NOTFOUND;
                end else if (r_in_byte == key_byte(key_cur)) begin
                    if (key_cur == KEY_LAST_IDX) begin
                        n_key   = '0;
                        n_phase = PH_SKIP;
                    end else begin
                        n_key = key_cur + t_key_cnt'(1);
                    end
                end else if (key_cur == KEY_LAST_IDX && r_in_byte == CH_T) begin
                    // closing quote restarts the key and 't' extends it
                    n_key = KEY_AFTER_QUOTE + t_key_cnt'(1);
                end else if (r_in_byte == CH_QUOTE) begin
                    n_key = KEY_AFTER_QUOTE;
                end else begin
                    n_key = '0;
                end
            end
            PH_SKIP: begin
                if (is_digit) begin
                    n_acc   = digit_val;
                    n_phase = PH_DIGITS;
                end else if (!is_blank) begin
                    n_phase = PH_NOTFOUND;
                end
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    n_acc = acc_times10 + digit_val;
                end else begin
                    n_phase = PH_FOUND;
                end
            end
            default: begin
                // line finished, rest ignored
            end
        endcase
    end

    assign ok = (n_phase == PH_DIGITS) || (n_phase == PH_FOUND);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_byte <= i_text_byte;
            r_in_last <= i_line_end;
        end
    end

    // scanning state, back to reset values after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_key   <= '0;
            r_acc   <= '0;
        end else if (advance) begin
            if (r_in_last) begin
                r_phase <= PH_SEARCH;
                r_key   <= '0;
                r_acc   <= '0;
            end else begin
                r_phase <= n_phase;
                r_key   <= n_key;
                r_acc   <= n_acc;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_found <= ok;
            r_value <= ok ? n_acc : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_stamp_value = r_value;

endmodule

@@ hw/rtl/tfe_checker.sv @@
// tfe_checker: port-level assertions for timestamp_field_extractor
// depends on tfe_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module tfe_checker
    import tfe_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_found,
    input logic [63:0] o_stamp_value
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a not-found transaction carries a zero value
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_stamp_value == 64'd0))
        else $error("not-found result with nonzero value");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result dropped");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_found) && $stable(o_stamp_value)))
        else $error("stalled result payload changed");

    // the input stalls only behind a held result
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

endmodule

bind timestamp_field_extractor tfe_checker u_tfe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_found       (o_found),
    .o_stamp_value (o_stamp_value)
);
